[hdl/gdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types and constants of the gamepad dead zone conditioner.
// ----------------------------------------------------------------------------
package gdc_pkg;

  // One gamepad poll as it enters the block.
  typedef struct packed {
    logic               pad_present;
    logic [15:0]        raw_buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
  } poll_t;

  // One conditioned result.
  typedef struct packed {
    logic               link_up;
    logic [21:0]        button_mask;
    logic signed [15:0] left_x_scaled;
    logic signed [15:0] left_y_scaled;
    logic signed [15:0] right_x_scaled;
    logic signed [15:0] right_y_scaled;
    logic               activity;
  } result_t;

  // Configuration register contents.
  typedef struct packed {
    logic [14:0] left_stick_deadzone;
    logic [14:0] right_stick_deadzone;
    logic [7:0]  trigger_deadzone;
    logic [14:0] axis_press_threshold;
    logic [14:0] trigger_press_threshold;
  } cfg_t;

  // Request to the shared divider: quotient = (mag*65536 + den) / (2*den).
  typedef struct packed {
    logic        start;
    logic [15:0] mag;
    logic [15:0] den;
  } div_req_t;

  // Divider response, done pulses for one cycle.
  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

  // Register indexes (byte address is 4 times the index).
  localparam logic [2:0] REG_LEFT_DZ   = 3'd0;
  localparam logic [2:0] REG_RIGHT_DZ  = 3'd1;
  localparam logic [2:0] REG_TRIG_DZ   = 3'd2;
  localparam logic [2:0] REG_AXIS_THR  = 3'd3;
  localparam logic [2:0] REG_TRIG_THR  = 3'd4;

  // Reset values of the registers.
  localparam logic [14:0] RST_LEFT_DZ  = 15'd7849;
  localparam logic [14:0] RST_RIGHT_DZ = 15'd8689;
  localparam logic [7:0]  RST_TRIG_DZ  = 8'd30;
  localparam logic [14:0] RST_AXIS_THR = 15'd16384;
  localparam logic [14:0] RST_TRIG_THR = 15'd16384;

  // Divider produces two quotient bits per cycle until its counter reaches this value.
  localparam logic [2:0] DIV_LAST = 3'd7;

  // Job order of the sequencer: four axes, then two triggers.
  localparam logic [2:0] JOB_LX   = 3'd0;
  localparam logic [2:0] JOB_LY   = 3'd1;
  localparam logic [2:0] JOB_RX   = 3'd2;
  localparam logic [2:0] JOB_RY   = 3'd3;
  localparam logic [2:0] JOB_LT   = 3'd4;
  localparam logic [2:0] JOB_RT   = 3'd5;

  // Full scale values.
  localparam logic [15:0] AXIS_POS_FULL = 16'd32767;
  localparam logic [15:0] AXIS_NEG_FULL = 16'd32768;
  localparam logic [8:0]  TRIG_FULL     = 9'd256;

endpackage : gdc_pkg
`default_nettype wire

[hdl/gdc_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_cfg_regs
// APB register file holding the dead zones and press thresholds.
// ----------------------------------------------------------------------------
module gdc_cfg_regs import gdc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_stick_deadzone     <= RST_LEFT_DZ;
      cfg.right_stick_deadzone    <= RST_RIGHT_DZ;
      cfg.trigger_deadzone        <= RST_TRIG_DZ;
      cfg.axis_press_threshold    <= RST_AXIS_THR;
      cfg.trigger_press_threshold <= RST_TRIG_THR;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LEFT_DZ:  cfg.left_stick_deadzone     <= pwdata[14:0];
        REG_RIGHT_DZ: cfg.right_stick_deadzone    <= pwdata[14:0];
        REG_TRIG_DZ:  cfg.trigger_deadzone        <= pwdata[7:0];
        REG_AXIS_THR: cfg.axis_press_threshold    <= pwdata[14:0];
        REG_TRIG_THR: cfg.trigger_press_threshold <= pwdata[14:0];
        default: begin
        end
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      REG_LEFT_DZ:  prdata = {17'd0, cfg.left_stick_deadzone};
      REG_RIGHT_DZ: prdata = {17'd0, cfg.right_stick_deadzone};
      REG_TRIG_DZ:  prdata = {24'd0, cfg.trigger_deadzone};
      REG_AXIS_THR: prdata = {17'd0, cfg.axis_press_threshold};
      REG_TRIG_THR: prdata = {17'd0, cfg.trigger_press_threshold};
      default:      prdata = 32'd0;
    endcase
  end

endmodule : gdc_cfg_regs
`default_nettype wire

[hdl/gdc_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_divider
// Shared restoring divider, two quotient bits per cycle, rounding scaler.
// ----------------------------------------------------------------------------
module gdc_divider import gdc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  // The dividend is {mag, den}; its upper half is always below the divisor,
  // so sixteen restoring steps give the whole quotient.
  logic        busy;
  logic        done;
  logic [2:0]  cnt;
  logic [16:0] rem;
  logic [16:0] dsr;
  logic [15:0] shreg;

  logic [17:0] t1, t2;
  logic        ge1, ge2;
  logic [16:0] r1, r2;

  // Two chained compare and subtract steps.
  always_comb begin
    t1  = {rem, shreg[15]};
    ge1 = t1 >= {1'b0, dsr};
    r1  = ge1 ? 17'(t1 - {1'b0, dsr}) : t1[16:0];
    t2  = {r1, shreg[14]};
    ge2 = t2 >= {1'b0, dsr};
    r2  = ge2 ? 17'(t2 - {1'b0, dsr}) : t2[16:0];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= 3'(cnt + 3'd1);
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath; the low dividend bits shift out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= {1'b0, req.mag};
      dsr   <= {req.den, 1'b0};
      shreg <= req.den;
    end else if (busy) begin
      rem   <= r2;
      shreg <= {shreg[13:0], ge1, ge2};
    end
  end

  assign rsp = {done, shreg};

endmodule : gdc_divider
`default_nettype wire

[hdl/gamepad_deadzone_conditioner.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_deadzone_conditioner
// Dead zone and rescaling of sticks and triggers, button remap and activity.
// ----------------------------------------------------------------------------
// A disconnected poll goes straight to the result register. Otherwise each axis or
// trigger in turn is either divided, if outside its dead zone, or written as zero.
// One poll at a time: poll_stall holds new polls until the result register takes
// the finished poll; the divisions share one two-bit-per-cycle divider. The result
// register frees the input side.
// Reset: synchronous; registers return to their defaults and activity clears.
// ----------------------------------------------------------------------------
module gamepad_deadzone_conditioner import gdc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        poll_valid,
  output logic             poll_stall,
  input  wire poll_t       poll,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOAD   = 4'b0010,
    S_WAIT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t   state;
  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  poll_t       item;
  logic [2:0]  job;
  logic        activity_flag;
  logic [15:0] scaled [0:5];
  logic [5:0]  hit_pos;
  logic [5:0]  hit_neg;

  gdc_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gdc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Operand selection for the current job.
  logic signed [15:0] axis_raw;
  logic [14:0]        axis_dz;
  logic [7:0]         trig_raw;
  logic               is_trig;
  logic signed [16:0] a_ext, d_ext;
  logic               axis_pos, axis_neg, trig_on, active, negative;
  logic [15:0]        sel_mag, sel_den;

  always_comb begin
    case (job)
      JOB_LX:  axis_raw = item.left_x;
      JOB_LY:  axis_raw = item.left_y;
      JOB_RX:  axis_raw = item.right_x;
      default: axis_raw = item.right_y;
    endcase
    axis_dz  = (job == JOB_LX || job == JOB_LY) ? cfg.left_stick_deadzone
                                                : cfg.right_stick_deadzone;
    trig_raw = (job == JOB_LT) ? item.left_trigger : item.right_trigger;
    is_trig  = (job == JOB_LT) || (job == JOB_RT);

    a_ext    = {axis_raw[15], axis_raw};
    d_ext    = {2'b00, axis_dz};
    axis_pos = a_ext > d_ext;
    axis_neg = a_ext < -d_ext;
    trig_on  = trig_raw > cfg.trigger_deadzone;

    if (is_trig) begin
      sel_mag = {8'd0, 8'(trig_raw - cfg.trigger_deadzone)};
      sel_den = {7'd0, 9'(TRIG_FULL - {1'b0, cfg.trigger_deadzone})};
    end else if (axis_neg) begin
      sel_mag = 16'(-a_ext - d_ext);
      sel_den = 16'(AXIS_NEG_FULL - {1'b0, axis_dz});
    end else begin
      sel_mag = 16'(a_ext - d_ext);
      sel_den = 16'(AXIS_POS_FULL - {1'b0, axis_dz});
    end

    active   = is_trig ? trig_on : (axis_pos || axis_neg);
    negative = !is_trig && axis_neg;
  end

  assign div_req = {(state == S_LOAD) && active, sel_mag, sel_den};

  // Sign, saturation and threshold compare of the finished job.
  logic [15:0]        wb_val;
  logic [14:0]        thr;
  logic signed [16:0] v_ext, thr_pos, thr_neg;
  logic               wb_en, wb_pos, wb_neg;

  always_comb begin
    if (!active) begin
      wb_val = 16'd0;
    end else if (negative) begin
      wb_val = 16'(~div_rsp.quot + 16'd1);
    end else if (div_rsp.quot[15]) begin
      wb_val = AXIS_POS_FULL;
    end else begin
      wb_val = div_rsp.quot;
    end
    thr     = is_trig ? cfg.trigger_press_threshold : cfg.axis_press_threshold;
    v_ext   = {wb_val[15], wb_val};
    thr_pos = {2'b00, thr};
    thr_neg = -thr_pos;
    wb_pos  = v_ext > thr_pos;
    wb_neg  = v_ext < thr_neg;
    wb_en   = ((state == S_LOAD) && !active) || ((state == S_WAIT) && div_rsp.done);
  end

  // Result assembly.
  logic [21:0] mask;
  logic        any_input;

  always_comb begin
    mask = {hit_neg[JOB_RX], hit_pos[JOB_RX], hit_neg[JOB_LY], hit_pos[JOB_LY],
            hit_neg[JOB_LX], hit_pos[JOB_LX], hit_pos[JOB_RT], hit_pos[JOB_LT],
            item.raw_buttons[15:12], item.raw_buttons[9:0]};
    any_input = (|mask) || (|scaled[JOB_LX]) || (|scaled[JOB_LY]) ||
                (|scaled[JOB_RX]) || (|scaled[JOB_RY]);
  end

  // The finished poll moves into the output register once that register is free.
  logic result_load;

  assign result_load = (state == S_FINISH) && (!result_valid || !result_stall);

  assign poll_stall = rst || (state != S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      job           <= '0;
      result_valid  <= 1'b0;
      activity_flag <= 1'b0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (poll_valid) begin
            job   <= JOB_LX;
            state <= poll.pad_present ? S_LOAD : S_FINISH;
          end
        end
        S_LOAD, S_WAIT: begin
          if (div_req.start) begin
            state <= S_WAIT;
          end else if (wb_en) begin
            if (job == JOB_RT) begin
              state <= S_FINISH;
            end else begin
              job   <= 3'(job + 3'd1);
              state <= S_LOAD;
            end
          end
        end
        S_FINISH: begin
          if (result_load) begin
            if (item.pad_present) begin
              activity_flag <= any_input;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Poll capture and per-job results.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && poll_valid) begin
      item <= poll;
    end
    if (wb_en) begin
      scaled[job]  <= wb_val;
      hit_pos[job] <= wb_pos;
      hit_neg[job] <= wb_neg;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && (!result_valid || !result_stall)) begin
      result.link_up  <= item.pad_present;
      result.activity <= item.pad_present ? any_input : activity_flag;
      if (item.pad_present) begin
        result.button_mask    <= mask;
        result.left_x_scaled  <= scaled[JOB_LX];
        result.left_y_scaled  <= scaled[JOB_LY];
        result.right_x_scaled <= scaled[JOB_RX];
        result.right_y_scaled <= scaled[JOB_RY];
      end else begin
        result.button_mask    <= '0;
        result.left_x_scaled  <= '0;
        result.left_y_scaled  <= '0;
        result.right_x_scaled <= '0;
        result.right_y_scaled <= '0;
      end
    end
  end

endmodule : gamepad_deadzone_conditioner
`default_nettype wire
